FILE: hw/rtl/odo_pkg.sv
// Shared types and constants for the differential drive odometry block.
// Used by the front, queue, back and top-level modules; depends on nothing.
`default_nettype none

package odo_pkg;

	// Default number of CORDIC rotations.
	localparam int CORDIC_STEPS_DEF = 24;

	// Fixed-point scale constants.
	localparam logic [29:0] BAM_PER_RAD   = 30'd683565276;   // round(2^32 / (2 pi))
	localparam logic [32:0] GYRO_BAM_Q16  = 33'd4479813390;  // 0.0001 rad as Q.16 binary angle
	localparam logic [33:0] CORDIC_GAIN   = 34'd652032874;   // inverse of the CORDIC gain in Q.30

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_HEADING_MODE = 3'd0;
	localparam logic [2:0] REG_LEFT_SCALE   = 3'd1;
	localparam logic [2:0] REG_RIGHT_SCALE  = 3'd2;
	localparam logic [2:0] REG_INV_TRACK    = 3'd3;
	localparam logic [2:0] REG_GYRO_BIAS    = 3'd4;

	// Arctangent table as binary angles.
	localparam logic [31:0] ATAN_BAM [32] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
		32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
	};

	// One classified item passed from the front to the back.
	typedef struct packed {
		logic               gyro_mode;
		logic signed [31:0] dcnt_l;
		logic signed [31:0] dcnt_r;
		logic signed [16:0] rate;
	} odo_entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} odo_fifo_stat_t;

	typedef struct packed {
		logic idle;
		logic result_load;
	} odo_back_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/odo_front.sv
// Front part: takes input words, forms count differences and the corrected gyro rate.
// Depends on odo_pkg.
`default_nettype none

module odo_front import odo_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire logic               queue_full,
	input  wire logic signed [31:0] left_total,
	input  wire logic signed [31:0] right_total,
	input  wire logic signed [15:0] gyro_rate,
	input  wire logic               heading_mode,
	input  wire logic signed [15:0] gyro_bias,
	output      logic               queue_push,
	output      odo_entry_t         entry
);

	logic signed [31:0] prev_left_q;
	logic signed [31:0] prev_right_q;

	assign queue_push = push && !queue_full;

	always_comb begin
		entry.gyro_mode = heading_mode;
		entry.dcnt_l    = left_total - prev_left_q;
		entry.dcnt_r    = right_total - prev_right_q;
		entry.rate      = 17'(gyro_rate) - 17'(gyro_bias);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_left_q  <= '0;
			prev_right_q <= '0;
		end else if (queue_push) begin
			prev_left_q  <= left_total;
			prev_right_q <= right_total;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/odo_fifo.sv
// Two-entry queue that decouples the front from the back.
// Depends on odo_pkg.
`default_nettype none

module odo_fifo import odo_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   wr_en,
	input  odo_entry_t  wr_data,
	input  wire logic   rd_en,
	output odo_entry_t  rd_data,
	output odo_fifo_stat_t stat
);

	odo_entry_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign rd_data    = mem_q[rd_ptr_q];
	assign stat.empty = (count_q == 2'd0);
	assign stat.full  = (count_q == 2'd2);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/odo_back.sv
// Back part: sequencer that scales travel, advances heading, runs the CORDIC and
// integrates position, with the result word register. Depends on odo_pkg.
`default_nettype none

module odo_back import odo_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [31:0] left_scale,
	input  wire logic [31:0] right_scale,
	input  wire logic [31:0] inv_track,
	input  odo_entry_t       entry,
	input  wire logic        queue_empty,
	output      logic        queue_pop,
	input  wire logic        res_pop,
	output      logic        res_valid,
	output      logic signed [47:0] res_x,
	output      logic signed [47:0] res_y,
	output      logic [31:0] res_heading,
	output odo_back_stat_t   stat
);

	typedef enum logic [3:0] {
		S_IDLE, S_TRAVEL, S_ANGLE, S_RAD, S_INC, S_HEAD, S_ROT, S_MUL, S_ACC, S_DONE
	} state_t;

	state_t             state_q;
	logic               mode_q;
	logic signed [31:0] cnt_l_q, cnt_r_q;
	logic signed [16:0] rate_q;
	logic signed [40:0] trav_l_q, trav_r_q, mean_q;
	logic signed [32:0] diff_q, rad_q;
	logic [31:0]        inc_q, heading_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic               flip_q;
	logic [4:0]         step_q;
	logic [1:0]         ph_q;
	logic signed [58:0] px_hi_q, px_lo_q, py_hi_q, py_lo_q;
	logic signed [47:0] pos_x_q, pos_y_q;
	logic               out_valid_q;
	logic signed [47:0] out_x_q, out_y_q;
	logic [31:0]        out_head_q;

	logic signed [64:0] prod_l, prod_r, rnd_l, rnd_r;
	logic signed [41:0] tsum, tdiff;
	logic signed [32:0] diff_sat;
	logic signed [50:0] gprod, grnd;
	logic signed [65:0] rprod, rrnd;
	logic signed [49:0] rad_full;
	logic signed [32:0] rad_sat;
	logic signed [63:0] iprod, irnd;
	logic [31:0]        new_head, z_start;
	logic               new_flip;
	logic signed [33:0] xs, ys, at;
	logic signed [33:0] cx, sy;
	logic signed [24:0] mh, ml, mul_a;
	logic signed [33:0] mul_b;
	logic signed [58:0] mprod;
	logic signed [59:0] tx, ty;
	logic signed [49:0] nx, ny;
	logic signed [47:0] sat_x, sat_y;
	logic               load_out;

	localparam logic signed [41:0] LIM42_P = 42'sd2147483648;
	localparam logic signed [41:0] LIM42_N = -42'sd2147483648;
	localparam logic signed [49:0] LIM50_P = 50'sd2147483648;
	localparam logic signed [49:0] LIM50_N = -50'sd2147483648;
	localparam logic signed [49:0] POS50_P = 50'sd140737488355327;
	localparam logic signed [49:0] POS50_N = -50'sd140737488355328;

	// Travel per wheel, rounded Q.16.
	assign prod_l = cnt_l_q * $signed({1'b0, left_scale});
	assign prod_r = cnt_r_q * $signed({1'b0, right_scale});
	assign rnd_l  = prod_l + 65'sd8388608;
	assign rnd_r  = prod_r + 65'sd8388608;

	// Mean travel and clamped travel difference.
	assign tsum  = 42'(trav_l_q) + 42'(trav_r_q);
	assign tdiff = 42'(trav_r_q) - 42'(trav_l_q);
	always_comb begin
		if (tdiff > LIM42_P) begin
			diff_sat = 33'(LIM42_P);
		end else if (tdiff < LIM42_N) begin
			diff_sat = 33'(LIM42_N);
		end else begin
			diff_sat = tdiff[32:0];
		end
	end

	// Gyro increment.
	assign gprod = rate_q * $signed({1'b0, GYRO_BAM_Q16});
	assign grnd  = gprod + 51'sd32768;

	// Angle in radians, clamped.
	assign rprod    = diff_q * $signed({1'b0, inv_track});
	assign rrnd     = rprod + 66'sd32768;
	assign rad_full = rrnd[65:16];
	always_comb begin
		if (rad_full > LIM50_P) begin
			rad_sat = 33'(LIM50_P);
		end else if (rad_full < LIM50_N) begin
			rad_sat = 33'(LIM50_N);
		end else begin
			rad_sat = rad_full[32:0];
		end
	end

	// Radians to binary angle.
	assign iprod = rad_q * $signed({1'b0, BAM_PER_RAD});
	assign irnd  = iprod + 64'sd8388608;

	// Heading update and fold into the right half plane.
	assign new_head = heading_q + inc_q;
	assign new_flip = new_head[31] ^ new_head[30];
	assign z_start  = new_head + {new_flip, 31'd0};

	// One CORDIC rotation.
	assign xs = x_q >>> step_q;
	assign ys = y_q >>> step_q;
	assign at = $signed(34'(ATAN_BAM[step_q]));

	// Shared multiplier for the position step, split into high and low halves of mean.
	assign cx    = flip_q ? -x_q : x_q;
	assign sy    = flip_q ? -y_q : y_q;
	assign mh    = mean_q[40:16];
	assign ml    = $signed({9'd0, mean_q[15:0]});
	assign mul_a = ph_q[0] ? ml : mh;
	assign mul_b = ph_q[1] ? sy : cx;
	assign mprod = mul_a * mul_b;

	assign tx = 60'(px_hi_q) + 60'(px_lo_q >>> 16);
	assign ty = 60'(py_hi_q) + 60'(py_lo_q >>> 16);
	assign nx = 50'(pos_x_q) + 50'($signed(tx[59:14]));
	assign ny = 50'(pos_y_q) + 50'($signed(ty[59:14]));

	always_comb begin
		if (nx > POS50_P) begin
			sat_x = 48'(POS50_P);
		end else if (nx < POS50_N) begin
			sat_x = 48'(POS50_N);
		end else begin
			sat_x = nx[47:0];
		end
		if (ny > POS50_P) begin
			sat_y = 48'(POS50_P);
		end else if (ny < POS50_N) begin
			sat_y = 48'(POS50_N);
		end else begin
			sat_y = ny[47:0];
		end
	end

	assign queue_pop        = (state_q == S_IDLE) && !queue_empty;
	assign load_out         = (state_q == S_DONE) && (!out_valid_q || res_pop);
	assign stat.idle        = (state_q == S_IDLE);
	assign stat.result_load = load_out;

	assign res_valid   = out_valid_q;
	assign res_x       = out_x_q;
	assign res_y       = out_y_q;
	assign res_heading = out_head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			heading_q   <= '0;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			out_valid_q <= 1'b0;
			step_q      <= '0;
			ph_q        <= '0;
		end else begin
			if (res_pop && out_valid_q && !load_out) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!queue_empty) begin
						mode_q  <= entry.gyro_mode;
						cnt_l_q <= entry.dcnt_l;
						cnt_r_q <= entry.dcnt_r;
						rate_q  <= entry.rate;
						state_q <= S_TRAVEL;
					end
				end
				S_TRAVEL: begin
					trav_l_q <= rnd_l[64:24];
					trav_r_q <= rnd_r[64:24];
					state_q  <= S_ANGLE;
				end
				S_ANGLE: begin
					mean_q <= tsum[41:1];
					diff_q <= diff_sat;
					if (mode_q) begin
						inc_q   <= grnd[47:16];
						state_q <= S_HEAD;
					end else begin
						state_q <= S_RAD;
					end
				end
				S_RAD: begin
					rad_q   <= rad_sat;
					state_q <= S_INC;
				end
				S_INC: begin
					inc_q   <= irnd[55:24];
					state_q <= S_HEAD;
				end
				S_HEAD: begin
					heading_q <= new_head;
					flip_q    <= new_flip;
					z_q       <= 34'($signed(z_start));
					x_q       <= $signed(CORDIC_GAIN);
					y_q       <= '0;
					step_q    <= '0;
					state_q   <= S_ROT;
				end
				S_ROT: begin
					if (!z_q[33]) begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - at;
					end else begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + at;
					end
					step_q <= step_q + 5'd1;
					if (step_q == 5'(CORDIC_STEPS - 1)) begin
						ph_q    <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					case (ph_q)
						2'd0:    px_hi_q <= mprod;
						2'd1:    px_lo_q <= mprod;
						2'd2:    py_hi_q <= mprod;
						default: py_lo_q <= mprod;
					endcase
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd3) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					pos_x_q <= sat_x;
					pos_y_q <= sat_y;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load_out) begin
						out_x_q     <= pos_x_q;
						out_y_q     <= pos_y_q;
						out_head_q  <= heading_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/differential_drive_odometry.sv
// Differential drive wheel odometry: top level with the configuration registers.
// The back sequencer's iterative CORDIC sets the pace: it works on one word at a time, and
// gyro mode skips its radian and increment states. The queue takes new words meanwhile.
// Reset clears registers, encoder history, heading and position to zero.
// Depends on odo_pkg, odo_front, odo_fifo and odo_back.
`default_nettype none

module differential_drive_odometry import odo_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// Input queue side.
	input  wire logic               push,
	output      logic               full,
	input  wire logic signed [31:0] left_total,
	input  wire logic signed [31:0] right_total,
	input  wire logic signed [15:0] gyro_rate,
	// Result side.
	output      logic               empty,
	input  wire logic               pop,
	output      logic signed [47:0] pos_x_out,
	output      logic signed [47:0] pos_y_out,
	output      logic [31:0]        heading_out,
	// Configuration port.
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [4:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output      logic [31:0]        prdata,
	output      logic               pready
);

	// Configuration registers. The user must see that they are written only while the block is idle,
	// so the back part reads them directly; the block itself does not enforce this.
	logic               heading_mode_q;
	logic [31:0]        left_scale_q;
	logic [31:0]        right_scale_q;
	logic [31:0]        inv_track_q;
	logic signed [15:0] gyro_bias_q;

	logic [2:0] reg_idx;
	logic       cfg_wr;

	odo_entry_t     front_entry;
	odo_entry_t     queue_entry;
	logic           queue_push;
	logic           queue_pop;
	odo_fifo_stat_t fifo_stat;
	odo_back_stat_t back_stat;
	logic           res_valid;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heading_mode_q <= 1'b0;
			left_scale_q   <= '0;
			right_scale_q  <= '0;
			inv_track_q    <= '0;
			gyro_bias_q    <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_HEADING_MODE: heading_mode_q <= pwdata[0];
				REG_LEFT_SCALE:   left_scale_q   <= pwdata;
				REG_RIGHT_SCALE:  right_scale_q  <= pwdata;
				REG_INV_TRACK:    inv_track_q    <= pwdata;
				REG_GYRO_BIAS:    gyro_bias_q    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read back; addresses beyond the list read as zero.
	always_comb begin
		unique case (reg_idx)
			REG_HEADING_MODE: prdata = {31'd0, heading_mode_q};
			REG_LEFT_SCALE:   prdata = left_scale_q;
			REG_RIGHT_SCALE:  prdata = right_scale_q;
			REG_INV_TRACK:    prdata = inv_track_q;
			REG_GYRO_BIAS:    prdata = {16'd0, gyro_bias_q};
			default:          prdata = '0;
		endcase
	end

	// The front takes a word whenever the queue has room, so the input stalls only when
	// two words wait behind the one the back is working on.
	assign full = fifo_stat.full;

	odo_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.queue_full   (fifo_stat.full),
		.left_total   (left_total),
		.right_total  (right_total),
		.gyro_rate    (gyro_rate),
		.heading_mode (heading_mode_q),
		.gyro_bias    (gyro_bias_q),
		.queue_push   (queue_push),
		.entry        (front_entry)
	);

	odo_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (queue_push),
		.wr_data (front_entry),
		.rd_en   (queue_pop),
		.rd_data (queue_entry),
		.stat    (fifo_stat)
	);

	// The back keeps heading and position, and holds the finished result in its output
	// register so it can start on the next word while the result waits to be popped.
	odo_back #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.left_scale  (left_scale_q),
		.right_scale (right_scale_q),
		.inv_track   (inv_track_q),
		.entry       (queue_entry),
		.queue_empty (fifo_stat.empty),
		.queue_pop   (queue_pop),
		.res_pop     (pop && res_valid),
		.res_valid   (res_valid),
		.res_x       (pos_x_out),
		.res_y       (pos_y_out),
		.res_heading (heading_out),
		.stat        (back_stat)
	);

	assign empty = !res_valid;

	// The back takes a word from the queue only when it is idle.
	a_pop_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		queue_pop |-> back_stat.idle)
		else $error("queue read while the back was busy");

	// A waiting word in the queue is picked up at once by an idle back.
	a_idle_picks_up: assert property (@(posedge clk) disable iff (!arst_n)
		(back_stat.idle && !fifo_stat.empty) |=> !back_stat.idle)
		else $error("idle back did not start on a queued word");

	// A result appears only through a load from the back sequencer.
	a_result_from_back: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(empty) |-> $past(back_stat.result_load))
		else $error("result appeared without a load");

endmodule

`default_nettype wire

FILE: tb/differential_drive_odometry_tb.sv
// Testbench for differential_drive_odometry: pushes encoder and gyro words through the
// block and checks each result against an in-bench fixed-point odometry predictor.
// Depends on odo_pkg and the differential_drive_odometry RTL.
`default_nettype none

module differential_drive_odometry_tb import odo_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int  STEPS       = 24;
	localparam int  CYCLE_LIMIT = 1000000;
	localparam int  DRAIN_WAIT  = 60;
	localparam longint POS_HI   = 64'sh00007FFFFFFFFFFF;
	localparam longint POS_LO   = -64'sh0000800000000000;

	// One expected result word.
	typedef struct {
		logic signed [47:0] x;
		logic signed [47:0] y;
		logic [31:0]        h;
	} pose_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic signed [31:0] left_total = '0;
	logic signed [31:0] right_total = '0;
	logic signed [15:0] gyro_rate = '0;
	logic               empty;
	logic               pop = 1'b0;
	logic signed [47:0] pos_x_out;
	logic signed [47:0] pos_y_out;
	logic [31:0]        heading_out;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [4:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	differential_drive_odometry #(.CORDIC_STEPS(STEPS)) u_top (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full),
		.left_total(left_total), .right_total(right_total), .gyro_rate(gyro_rate),
		.empty(empty), .pop(pop),
		.pos_x_out(pos_x_out), .pos_y_out(pos_y_out), .heading_out(heading_out),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Shadow of the configuration registers and of the block's odometry state.
	logic               cfg_gyro_mode;
	logic [31:0]        cfg_left_scale;
	logic [31:0]        cfg_right_scale;
	logic [31:0]        cfg_inv_track;
	logic signed [15:0] cfg_bias;
	logic [31:0]        last_left;
	logic [31:0]        last_right;
	logic [31:0]        heading_bam;
	longint             pose_x;
	longint             pose_y;

	pose_t  pending_poses[$];
	int     mismatches = 0;
	int     cycles = 0;
	int     idle_pct = 0;
	int     stall_pct = 0;

	// Encoder totals most recently sent, so that new words can be built from deltas.
	logic [31:0] sent_left = '0;
	logic [31:0] sent_right = '0;

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// Wheel travel in Q.16 from the wrapped count difference.
	function automatic longint wheel_travel(logic [31:0] now, logic [31:0] was,
			logic [31:0] scale);
		logic [31:0] raw;
		longint      dcount;
		raw = now - was;
		dcount = longint'(signed'(raw));
		return (dcount * longint'(scale) + (longint'(1) << 23)) >>> 24;
	endfunction

	// Product of a Q.16 distance with a Q.30 factor, split to stay inside 64 bits.
	function automatic longint scale_q30(longint m, longint c);
		longint hi_part;
		longint lo_part;
		hi_part = m >>> 16;
		lo_part = m & 64'hFFFF;
		return (hi_part * c + ((lo_part * c) >>> 16)) >>> 14;
	endfunction

	// Rotation-mode CORDIC; angles in the left half plane are turned half a turn first.
	task automatic rotate_unit(input logic [31:0] angle, output longint c, output longint s);
		logic   flip;
		longint x;
		longint y;
		longint z;
		longint xs;
		longint ys;
		flip = (angle[31:30] == 2'd1) || (angle[31:30] == 2'd2);
		if (flip) begin
			angle = angle + 32'h80000000;
		end
		z = longint'(signed'(angle));
		x = longint'(CORDIC_GAIN);
		y = 0;
		for (int i = 0; i < STEPS && i < 32; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys; y = y + xs; z = z - longint'(ATAN_BAM[i]);
			end else begin
				x = x + ys; y = y - xs; z = z + longint'(ATAN_BAM[i]);
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	// Advances the shadow state by one word and returns the pose it should produce.
	task automatic advance_pose(input logic [31:0] lt, input logic [31:0] rt,
			input logic signed [15:0] rate, output pose_t pose);
		longint lim;
		longint dl;
		longint dr;
		longint inc;
		longint rad;
		longint mean;
		longint c;
		longint s;
		lim = longint'(1) << 31;
		dl = wheel_travel(lt, last_left, cfg_left_scale);
		dr = wheel_travel(rt, last_right, cfg_right_scale);
		if (cfg_gyro_mode) begin
			inc = ((longint'(rate) - longint'(cfg_bias)) * longint'(GYRO_BAM_Q16)
				+ 32768) >>> 16;
		end else begin
			rad = (clamp(dr - dl, -lim, lim) * longint'(cfg_inv_track) + 32768) >>> 16;
			rad = clamp(rad, -lim, lim);
			inc = (rad * longint'(BAM_PER_RAD) + (longint'(1) << 23)) >>> 24;
		end
		heading_bam = heading_bam + inc[31:0];
		rotate_unit(heading_bam, c, s);
		mean = clamp((dl + dr) >>> 1, POS_LO, POS_HI);
		pose_x = clamp(pose_x + scale_q30(mean, c), POS_LO, POS_HI);
		pose_y = clamp(pose_y + scale_q30(mean, s), POS_LO, POS_HI);
		last_left = lt;
		last_right = rt;
		pose.x = pose_x[47:0];
		pose.y = pose_y[47:0];
		pose.h = heading_bam;
	endtask

	// Sends one word, honoring the sender idle rate, and records its expected pose.
	task automatic send_word(input logic [31:0] lt, input logic [31:0] rt,
			input logic signed [15:0] rate);
		pose_t pose;
		if ($urandom_range(99) < idle_pct) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		push <= 1'b1;
		left_total <= lt;
		right_total <= rt;
		gyro_rate <= rate;
		do @(posedge clk); while (full);
		advance_pose(lt, rt, rate, pose);
		pending_poses.push_back(pose);
		sent_left = lt;
		sent_right = rt;
	endtask

	// Sends a word that moves the wheels by the given count deltas.
	task automatic move(input logic [31:0] dl, input logic [31:0] dr,
			input logic signed [15:0] rate);
		send_word(sent_left + dl, sent_right + dr, rate);
	endtask

	// Lets the block go quiet: every result collected, then the DRAIN_WAIT delay.
	task automatic settle();
		push <= 1'b0;
		while (pending_poses.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// Two-phase register write; the shadow copy changes with the block.
	task automatic write_reg(input logic [4:0] addr, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (addr >> 2)
			REG_HEADING_MODE: cfg_gyro_mode = value[0];
			REG_LEFT_SCALE:   cfg_left_scale = value;
			REG_RIGHT_SCALE:  cfg_right_scale = value;
			REG_INV_TRACK:    cfg_inv_track = value;
			REG_GYRO_BIAS:    cfg_bias = value[15:0];
			default: ;
		endcase
	endtask

	task automatic configure(input logic mode, input logic [31:0] ls, input logic [31:0] rs,
			input logic [31:0] inv, input logic [15:0] bias);
		write_reg({REG_HEADING_MODE, 2'b00}, {31'd0, mode});
		write_reg({REG_LEFT_SCALE, 2'b00}, ls);
		write_reg({REG_RIGHT_SCALE, 2'b00}, rs);
		write_reg({REG_INV_TRACK, 2'b00}, inv);
		write_reg({REG_GYRO_BIAS, 2'b00}, {16'd0, bias});
	endtask

	// Field extremes, wrapping counts, saturated wheel difference, both heading rules.
	task automatic test_directed();
		// Everything at reset: zero scales give no motion at all.
		move(32'd1000, 32'd1000, 16'sd0);
		settle();
		configure(1'b0, 32'h0100_0000, 32'h0100_0000, 32'h0200_0000, 16'h0000);
		move(32'd100, 32'd100, 16'sd0);
		move(32'd0, 32'd50, 16'sd0);
		move(-32'd75, -32'd20, 16'sd0);
		// Counts crossing the signed wrap point.
		send_word(32'h7FFF_FFF0, 32'h7FFF_FFF8, 16'sd0);
		send_word(32'h8000_0010, 32'h8000_0004, 16'sd0);
		send_word(32'hFFFF_FFFF, 32'h0000_0000, 16'sd0);
		settle();
		// Huge opposite wheel moves saturate the travel difference.
		configure(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000);
		move(32'h8000_0000, 32'h7FFF_FFFF, 16'sd0);
		move(32'h7FFF_FFFF, 32'h8000_0000, 16'sd0);
		move(32'h8000_0000, 32'h8000_0000, 16'sd0);
		settle();
		// Gyro rule with the rate and bias at their limits; heading wraps.
		configure(1'b1, 32'h0080_0000, 32'h0080_0000, 32'h0000_0000, 16'h8000);
		move(32'd10, 32'd10, 16'sh7FFF);
		move(32'd10, 32'd10, -16'sh8000);
		settle();
		write_reg({REG_GYRO_BIAS, 2'b00}, 32'h0000_7FFF);
		move(32'd5, 32'd5, -16'sh8000);
		move(32'd5, 32'd5, 16'sh7FFF);
		for (int i = 0; i < 4; i++) move(32'd20, 32'd20, -16'sh8000);
		settle();
		// Addresses past the register list are ignored.
		write_reg(5'd20, 32'hFFFF_FFFF);
		write_reg(5'd28, 32'h1234_5678);
		move(32'd3, -32'd3, 16'sd100);
		settle();
	endtask

	// Full-scale straight runs that drive the position into both saturation limits.
	task automatic test_position_saturation();
		configure(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0100_0000, 16'h0000);
		for (int i = 0; i < 300; i++) move(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'sd0);
		for (int i = 0; i < 600; i++) move(32'h8000_0001, 32'h8000_0001, 16'sd0);
		settle();
	endtask

	function automatic logic [31:0] pick_scale();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'hFFFF_FFFF;
			default: return $urandom_range(32'h0040_0000, 32'h0400_0000);
		endcase
	endfunction

	// Random encoder and gyro traffic under one sender idle rate and one result stall rate.
	task automatic test_random_traffic(input int idle, input int stall, input int words);
		logic [31:0] dl;
		logic [31:0] dr;
		configure(1'($urandom_range(1)), pick_scale(), pick_scale(),
			$urandom_range(1) ? $urandom : $urandom_range(32'h0080_0000, 32'h0800_0000),
			16'($urandom));
		idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < words; i++) begin
			if ($urandom_range(9) == 0) begin
				send_word($urandom, $urandom, 16'($urandom));
			end else begin
				dl = $urandom_range(4000) - 2000;
				dr = $urandom_range(4000) - 2000;
				move(dl, dr, 16'($urandom));
			end
		end
		settle();
		idle_pct = 0;
		stall_pct = 0;
	endtask

	// Result side: random stalls, and each popped word is checked against the oldest pose.
	always @(posedge clk) begin
		pose_t want;
		if (pop && !empty) begin
			if (pending_poses.size() == 0) begin
				$error("unexpected word: x=%0d y=%0d heading=%0d",
					pos_x_out, pos_y_out, heading_out);
				mismatches++;
			end else begin
				want = pending_poses.pop_front();
				if (pos_x_out !== want.x) begin
					$error("pos_x_out expected %0d got %0d", want.x, pos_x_out);
					mismatches++;
				end
				if (pos_y_out !== want.y) begin
					$error("pos_y_out expected %0d got %0d", want.y, pos_y_out);
					mismatches++;
				end
				if (heading_out !== want.h) begin
					$error("heading_out expected %0d got %0d", want.h, heading_out);
					mismatches++;
				end
			end
		end
		pop <= arst_n && ($urandom_range(99) >= stall_pct);
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		cfg_gyro_mode = 1'b0;
		cfg_left_scale = '0;
		cfg_right_scale = '0;
		cfg_inv_track = '0;
		cfg_bias = '0;
		last_left = '0;
		last_right = '0;
		heading_bam = '0;
		pose_x = 0;
		pose_y = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_position_saturation();
		test_random_traffic(0, 0, 210);
		test_random_traffic(60, 0, 210);
		test_random_traffic(0, 60, 210);
		test_random_traffic(29, 29, 210);

		settle();
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

`default_nettype wire

FILE: files.f
hw/rtl/odo_pkg.sv
hw/rtl/odo_front.sv
hw/rtl/odo_fifo.sv
hw/rtl/odo_back.sv
hw/rtl/differential_drive_odometry.sv
tb/differential_drive_odometry_tb.sv
